// File: rtl/core/jp1d_pkg.sv
// Shared types, constants and codes of the 1D Jacobi Poisson solver.
package jp1d_pkg;

    // Fixed field widths of the request, response and configuration channels.
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 11;
    localparam int VAL_W     = 32;
    localparam int STEPS_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Defaults for the top-level parameters.
    localparam int MAX_INTERVALS_DEF = 1024;
    localparam int VALUE_BITS_DEF    = 32;

    // Configuration reset values.
    localparam logic [IDX_W-1:0]   INTERVAL_COUNT_RST = IDX_W'(100);
    localparam logic [STEPS_W-1:0] SWEEP_STEPS_RST    = STEPS_W'(100);
    localparam logic [VAL_W-1:0]   STEP_SQUARED_RST   = VAL_W'(429497);

    // Cycles spent after the last point of a sweep so that its writes land
    // before the next sweep reads its neighbors.
    localparam int DRAIN_CYCLES = 3;
    localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_RUN  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERVAL_COUNT = 2'd0,
        REG_SWEEP_STEPS    = 2'd1,
        REG_STEP_SQUARED   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SWEEP,
        ST_DRAIN
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_we;        // write u and rhs of the requested point
        logic issue;          // start the update of one interior point
        logic src_scratch;    // this sweep reads the scratch grid
        logic left_edge;      // left neighbor is boundary point 0
        logic right_edge;     // right neighbor is boundary point n
        logic res_write;      // load the response register
        logic res_done;       // response answers a finished run
        logic res_from_read;  // response carries the value read
        logic err;            // index out of range
    } dp_cmd_t;

endpackage

// File: rtl/core/jp1d_if.sv
// Request, response and configuration channel interfaces of the solver.
interface jp1d_req_if;
    import jp1d_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] u_value;
    logic signed [VAL_W-1:0] rhs_value;

    modport source (output valid, cmd, index, u_value, rhs_value, input ready);
    modport sink   (input valid, cmd, index, u_value, rhs_value, output ready);
endinterface

interface jp1d_rsp_if;
    import jp1d_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] point_value;
    logic                    run_done;
    logic                    index_error;

    modport source (output valid, point_value, run_done, index_error, input ready);
    modport sink   (input valid, point_value, run_done, index_error, output ready);
endinterface

interface jp1d_cfg_if;
    import jp1d_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] addr;
    logic [VAL_W-1:0]     data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// File: rtl/core/jp1d_ctrl.sv
// Controller state machine: request decode, sweep sequencing and response timing.
module jp1d_ctrl #(
    parameter int MAX_INTERVALS = jp1d_pkg::MAX_INTERVALS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    input  logic [jp1d_pkg::CMD_W-1:0]           req_cmd,
    input  logic [jp1d_pkg::IDX_W-1:0]           req_index,
    output logic                                 req_ready,
    input  logic [$clog2(MAX_INTERVALS+1)-1:0]   n_eff,
    input  logic [jp1d_pkg::STEPS_W-1:0]         sweep_steps,
    input  logic                                 res_valid,
    input  logic                                 out_ready,
    output jp1d_pkg::dp_cmd_t                    cmd,
    output logic [$clog2(MAX_INTERVALS+1)-1:0]   point
);
    import jp1d_pkg::*;

    localparam int ADDR_W = $clog2(MAX_INTERVALS + 1);
    localparam int CMP_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

    ctl_state_t           state_reg, state_next;
    logic [ADDR_W-1:0]    point_reg, point_next;
    logic [STEPS_W-1:0]   pair_reg, pair_next;
    logic                 src_reg, src_next;
    logic [DRAIN_W-1:0]   drain_reg, drain_next;
    logic                 err_reg, err_next;

    logic                 idx_err;
    logic [STEPS_W-1:0]   pairs;
    logic [ADDR_W-1:0]    last_point;
    logic                 no_interior;

    assign idx_err     = CMP_W'(req_index) > CMP_W'(n_eff);
    assign pairs       = STEPS_W'(({1'b0, sweep_steps} + (STEPS_W+1)'(1)) >> 1);
    assign last_point  = n_eff - ADDR_W'(1);
    assign no_interior = n_eff < ADDR_W'(2);
    assign point       = point_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            point_reg <= ADDR_W'(1);
            pair_reg  <= '0;
            src_reg   <= 1'b0;
            drain_reg <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            point_reg <= point_next;
            pair_reg  <= pair_next;
            src_reg   <= src_next;
            drain_reg <= drain_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        point_next = point_reg;
        pair_next  = pair_reg;
        src_next   = src_reg;
        drain_next = drain_reg;
        err_next   = err_reg;
        cmd        = '0;
        req_ready  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // The response register is free or empties in this cycle.
                req_ready = !res_valid || out_ready;
                if (req_valid && req_ready)
                begin
                    unique case (cmd_t'(req_cmd))
                        CMD_LOAD:
                        begin
                            cmd.load_we   = !idx_err;
                            cmd.err       = idx_err;
                            cmd.res_write = 1'b1;
                        end
                        CMD_READ:
                        begin
                            err_next   = idx_err;
                            state_next = ST_READ;
                        end
                        CMD_RUN:
                        begin
                            if (no_interior || pairs == '0)
                            begin
                                cmd.res_write = 1'b1;
                                cmd.res_done  = 1'b1;
                            end
                            else
                            begin
                                point_next = ADDR_W'(1);
                                pair_next  = pairs;
                                src_next   = 1'b0;
                                state_next = ST_SWEEP;
                            end
                        end
                        CMD_NOP:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.res_write     = 1'b1;
                cmd.res_from_read = 1'b1;
                cmd.err           = err_reg;
                state_next        = ST_IDLE;
            end
            ST_SWEEP:
            begin
                cmd.issue       = 1'b1;
                cmd.src_scratch = src_reg;
                cmd.left_edge   = point_reg == ADDR_W'(1);
                cmd.right_edge  = point_reg == last_point;
                if (point_reg == last_point)
                begin
                    drain_next = DRAIN_W'(DRAIN_CYCLES - 1);
                    state_next = ST_DRAIN;
                end
                else
                begin
                    point_next = point_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == '0)
                begin
                    point_next = ADDR_W'(1);
                    if (!src_reg)
                    begin
                        src_next   = 1'b1;
                        state_next = ST_SWEEP;
                    end
                    else if (pair_reg == STEPS_W'(1))
                    begin
                        cmd.res_write = 1'b1;
                        cmd.res_done  = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        pair_next  = pair_reg - STEPS_W'(1);
                        src_next   = 1'b0;
                        state_next = ST_SWEEP;
                    end
                end
                else
                begin
                    drain_next = drain_reg - DRAIN_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/jp1d_datapath.sv
// Datapath: grid memories, point update pipeline and response register.
module jp1d_datapath #(
    parameter int MAX_INTERVALS = jp1d_pkg::MAX_INTERVALS_DEF,
    parameter int VALUE_BITS    = jp1d_pkg::VALUE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  jp1d_pkg::dp_cmd_t                    cmd,
    input  logic [$clog2(MAX_INTERVALS+1)-1:0]   point,
    input  logic [jp1d_pkg::IDX_W-1:0]           index,
    input  logic signed [jp1d_pkg::VAL_W-1:0]    u_value,
    input  logic signed [jp1d_pkg::VAL_W-1:0]    rhs_value,
    input  logic [jp1d_pkg::VAL_W-1:0]           step_squared,
    input  logic                                 out_ready,
    output logic                                 res_valid,
    output logic signed [jp1d_pkg::VAL_W-1:0]    point_value,
    output logic                                 run_done,
    output logic                                 index_error
);
    import jp1d_pkg::*;

    localparam int DEPTH  = MAX_INTERVALS + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam int WIDE   = ((VALUE_BITS > VAL_W + 1) ? VALUE_BITS : VAL_W + 1) + 2;
    localparam int PROD_W = 2 * VAL_W + 1;

    localparam logic signed [WIDE-1:0] VMAX =
        {{(WIDE-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [WIDE-1:0] VMIN = ~VMAX;
    localparam logic signed [WIDE-1:0] OMAX = {{(WIDE-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [WIDE-1:0] OMIN = ~OMAX;

    logic signed [VALUE_BITS-1:0] sol_mem [DEPTH];
    logic signed [VALUE_BITS-1:0] scr_mem [DEPTH];
    logic signed [VAL_W-1:0]      rhs_mem [DEPTH];

    logic [CMP_W-1:0]  idx_ext;
    logic [ADDR_W-1:0] idx_addr;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;

    // Registered memory read data.
    logic signed [VALUE_BITS-1:0] sol_a_reg, sol_b_reg, scr_a_reg, scr_b_reg;
    logic signed [VAL_W-1:0]      rhs_rd_reg;

    // Stage 1: neighbors and rhs available.
    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_src_reg, s1_left_edge_reg, s1_right_edge_reg;
    logic signed [VALUE_BITS-1:0] left_sel, right_sel;
    logic signed [PROD_W-1:0]     prod;

    // Stage 2: scaled rhs and neighbors registered.
    logic                         s2_valid_reg;
    logic [ADDR_W-1:0]            s2_addr_reg;
    logic                         s2_to_scratch_reg;
    logic signed [VALUE_BITS-1:0] s2_left_reg, s2_right_reg;
    logic signed [VAL_W:0]        s2_t_reg;
    logic signed [WIDE-1:0]       sum_w, half_w, relax_w;
    logic signed [VALUE_BITS-1:0] relax_val;

    logic signed [WIDE-1:0]       u_wide, u_sat_w;
    logic signed [VALUE_BITS-1:0] u_sat;
    logic signed [WIDE-1:0]       rd_wide, rd_sat_w;

    logic                         sol_we, scr_we;
    logic [ADDR_W-1:0]            sol_wa;
    logic signed [VALUE_BITS-1:0] sol_wd;

    logic                    res_valid_reg, res_done_reg, res_err_reg;
    logic signed [VAL_W-1:0] res_value_reg;

    assign idx_ext  = CMP_W'(index);
    assign idx_addr = idx_ext[ADDR_W-1:0];
    assign addr_a   = cmd.issue ? point - ADDR_W'(1) : idx_addr;
    assign addr_b   = point + ADDR_W'(1);

    always_ff @(posedge clk)
    begin
        if (sol_we)
            sol_mem[sol_wa] <= sol_wd;
        if (scr_we)
            scr_mem[s2_addr_reg] <= relax_val;
        if (cmd.load_we)
            rhs_mem[idx_addr] <= rhs_value;
        sol_a_reg  <= sol_mem[addr_a];
        sol_b_reg  <= sol_mem[addr_b];
        scr_a_reg  <= scr_mem[addr_a];
        scr_b_reg  <= scr_mem[addr_b];
        rhs_rd_reg <= rhs_mem[point];
    end

    // Boundary points live only in the solution grid; the scratch copy of
    // them is never written, so edge neighbors always come from there.
    always_comb
    begin
        left_sel  = (s1_src_reg && !s1_left_edge_reg) ? scr_a_reg : sol_a_reg;
        right_sel = (s1_src_reg && !s1_right_edge_reg) ? scr_b_reg : sol_b_reg;
        prod      = PROD_W'(rhs_rd_reg) * PROD_W'($signed({1'b0, step_squared}));
    end

    // floor((left + right + t) / 2) computed exactly, then saturated.
    always_comb
    begin
        sum_w   = WIDE'(s2_left_reg) + WIDE'(s2_right_reg) + WIDE'(s2_t_reg);
        half_w  = sum_w >>> 1;
        relax_w = (half_w > VMAX) ? VMAX : ((half_w < VMIN) ? VMIN : half_w);
        relax_val = relax_w[VALUE_BITS-1:0];
    end

    always_comb
    begin
        u_wide   = WIDE'(u_value);
        u_sat_w  = (u_wide > VMAX) ? VMAX : ((u_wide < VMIN) ? VMIN : u_wide);
        u_sat    = u_sat_w[VALUE_BITS-1:0];
        rd_wide  = WIDE'(sol_a_reg);
        rd_sat_w = (rd_wide > OMAX) ? OMAX : ((rd_wide < OMIN) ? OMIN : rd_wide);
    end

    assign sol_we = cmd.load_we || (s2_valid_reg && !s2_to_scratch_reg);
    assign scr_we = s2_valid_reg && s2_to_scratch_reg;
    assign sol_wa = s2_valid_reg ? s2_addr_reg : idx_addr;
    assign sol_wd = cmd.load_we ? u_sat : relax_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.res_write)
                res_valid_reg <= 1'b1;
            else if (out_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg       <= point;
        s1_src_reg        <= cmd.src_scratch;
        s1_left_edge_reg  <= cmd.left_edge;
        s1_right_edge_reg <= cmd.right_edge;
        s2_addr_reg       <= s1_addr_reg;
        s2_to_scratch_reg <= !s1_src_reg;
        s2_left_reg       <= left_sel;
        s2_right_reg      <= right_sel;
        s2_t_reg          <= $signed(prod[PROD_W-1:VAL_W]);
        if (cmd.res_write)
        begin
            res_done_reg  <= cmd.res_done;
            res_err_reg   <= cmd.err;
            res_value_reg <= (cmd.res_from_read && !cmd.err) ? rd_sat_w[VAL_W-1:0] : '0;
        end
    end

    assign res_valid   = res_valid_reg;
    assign point_value = res_value_reg;
    assign run_done    = res_done_reg;
    assign index_error = res_err_reg;

endmodule

// File: rtl/core/jacobi_poisson_1d_solver_top.sv
// Top level of the 1D Jacobi Poisson solver: configuration registers and wiring.
//
//  Channel | Dir | Payload                                  | Request means
//  --------+-----+------------------------------------------+-------------------------
//  req     | in  | cmd, index, u_value, rhs_value           | load, run, read or no-op
//  rsp     | out | point_value, run_done, index_error       | one answer per load, run or read
//  cfg     | in  | addr, data                               | register write
//
// A load answers straight from idle; a read first passes the READ state so that
// the registered memory read is ready. A run performs 2*ceil(sweep_steps/2) sweeps,
// one point per cycle through the update pipeline, each sweep followed by a drain;
// with n < 2 or no sweeps it answers directly. Reset restores the register defaults;
// the grids are not cleared and hold nothing meaningful until loaded. Responses wait
// in an output register; when idle, a new request is taken while it is empty or draining.
module jacobi_poisson_1d_solver_top #(
    parameter int MAX_INTERVALS = jp1d_pkg::MAX_INTERVALS_DEF,
    parameter int VALUE_BITS    = jp1d_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    jp1d_req_if.sink    req,
    jp1d_rsp_if.source  rsp,
    jp1d_cfg_if.sink    cfg
);
    import jp1d_pkg::*;

    localparam int ADDR_W = $clog2(MAX_INTERVALS + 1);
    localparam int CMP_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam logic [CMP_W-1:0] MAX_N = CMP_W'(MAX_INTERVALS);

    logic [IDX_W-1:0]   interval_count_reg;
    logic [STEPS_W-1:0] sweep_steps_reg;
    logic [VAL_W-1:0]   step_squared_reg;

    logic [CMP_W-1:0]   n_cmp;
    logic [ADDR_W-1:0]  n_eff;
    dp_cmd_t            ctl_cmd;
    logic [ADDR_W-1:0]  point;
    logic               res_valid;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_count_reg <= INTERVAL_COUNT_RST;
            sweep_steps_reg    <= SWEEP_STEPS_RST;
            step_squared_reg   <= STEP_SQUARED_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.addr))
                REG_INTERVAL_COUNT: interval_count_reg <= cfg.data[IDX_W-1:0];
                REG_SWEEP_STEPS:    sweep_steps_reg    <= cfg.data[STEPS_W-1:0];
                REG_STEP_SQUARED:   step_squared_reg   <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // Interval counts above the grid size act as the grid size.
    assign n_cmp = (CMP_W'(interval_count_reg) > MAX_N) ? MAX_N : CMP_W'(interval_count_reg);
    assign n_eff = n_cmp[ADDR_W-1:0];

    jp1d_ctrl #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_cmd     (req.cmd),
        .req_index   (req.index),
        .req_ready   (req.ready),
        .n_eff       (n_eff),
        .sweep_steps (sweep_steps_reg),
        .res_valid   (res_valid),
        .out_ready   (rsp.ready),
        .cmd         (ctl_cmd),
        .point       (point)
    );

    jp1d_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctl_cmd),
        .point        (point),
        .index        (req.index),
        .u_value      (req.u_value),
        .rhs_value    (req.rhs_value),
        .step_squared (step_squared_reg),
        .out_ready    (rsp.ready),
        .res_valid    (res_valid),
        .point_value  (rsp.point_value),
        .run_done     (rsp.run_done),
        .index_error  (rsp.index_error)
    );

    assign rsp.valid = res_valid;

    // A response is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.res_write |-> (!res_valid || rsp.ready))
        else $error("response register overwritten");

    // No request is taken while a sweep is in progress.
    a_busy_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.issue |-> !req.ready)
        else $error("request accepted during a sweep");

    // Only interior points are updated.
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.issue |-> (point != '0 && point < n_eff))
        else $error("sweep issued a boundary point");

    // A run answer never carries an index error.
    a_done_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.run_done && rsp.index_error))
        else $error("run answer flagged an index error");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the 1D Jacobi Poisson solver with its own grid predictor.
module testbench;
    import jp1d_pkg::*;

    localparam int     HALF_PERIOD   = 2;
    localparam int     RESET_CYCLES  = 6;
    localparam int     GRID_LAST     = MAX_INTERVALS_DEF;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     END_CYCLES    = 16;
    localparam int     RANDOM_ITEMS  = 500;
    localparam int     REPORT_CAP    = 200;
    localparam longint LIMIT_NS      = 20_000_000;
    localparam longint VALUE_HI      = 64'sd2147483647;
    localparam longint VALUE_LO      = -64'sd2147483648;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_REG_WRITE,
        OP_WAIT_IDLE
    } op_kind_t;

    typedef struct {
        op_kind_t                kind;
        cmd_t                    cmd;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] u_value;
        logic signed [VAL_W-1:0] rhs_value;
        cfg_reg_t                reg_sel;
        logic [VAL_W-1:0]        reg_data;
    } grid_op_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] point_value;
        logic                    run_done;
        logic                    index_error;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n;

    jp1d_req_if req_ch ();
    jp1d_rsp_if rsp_ch ();
    jp1d_cfg_if cfg_ch ();

    jacobi_poisson_1d_solver_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    grid_op_t    op_queue[$];
    answer_t     expected_answers[$];
    int unsigned answers_due;
    int unsigned answers_seen;
    int unsigned mismatch_count = 0;
    int unsigned random_items;
    bit          point_loaded[0:GRID_LAST];

    // Predictor copy of the registers and grids.
    logic [IDX_W-1:0]   intervals_reg;
    logic [STEPS_W-1:0] sweeps_reg;
    logic [VAL_W-1:0]   h2_reg;
    longint             solution_copy[0:GRID_LAST];
    longint             scratch_copy[0:GRID_LAST];
    longint             rhs_copy[0:GRID_LAST];

    // Sender and receiver pacing.
    grid_op_t    in_flight;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned quiet_cycles;
    int unsigned stall_mode;
    int unsigned mode_left;
    int unsigned stall_phase;

    always #HALF_PERIOD clk = ~clk;

    function automatic longint clamp_value(longint x);
        if (x > VALUE_HI)
        begin
            return VALUE_HI;
        end
        if (x < VALUE_LO)
        begin
            return VALUE_LO;
        end
        return x;
    endfunction

    // One Jacobi update: floor((left + right + floor(rhs * h2 / 2^32)) / 2).
    function automatic longint relax_point(longint left, longint right, longint rhs);
        longint t;
        t = (rhs * longint'({32'd0, h2_reg})) >>> 32;
        return clamp_value((left + right + t) >>> 1);
    endfunction

    function automatic bit jacobi_answer(input grid_op_t op, output answer_t ans);
        int n;
        int pairs;
        ans = '0;
        n = (intervals_reg > GRID_LAST) ? GRID_LAST : int'(intervals_reg);
        case (op.cmd)
            CMD_LOAD:
            begin
                if (op.index > n)
                begin
                    ans.index_error = 1'b1;
                end
                else
                begin
                    solution_copy[op.index] = clamp_value(longint'(op.u_value));
                    rhs_copy[op.index] = longint'(op.rhs_value);
                end
            end
            CMD_RUN:
            begin
                pairs = (int'(sweeps_reg) + 1) / 2;
                scratch_copy[0] = solution_copy[0];
                scratch_copy[n] = solution_copy[n];
                if (n >= 2)
                begin
                    for (int p = 0; p < pairs; p++)
                    begin
                        for (int i = 1; i < n; i++)
                        begin
                            scratch_copy[i] = relax_point(solution_copy[i-1],
                                                          solution_copy[i+1], rhs_copy[i]);
                        end
                        for (int i = 1; i < n; i++)
                        begin
                            solution_copy[i] = relax_point(scratch_copy[i-1],
                                                           scratch_copy[i+1], rhs_copy[i]);
                        end
                    end
                end
                ans.run_done = 1'b1;
            end
            CMD_READ:
            begin
                if (op.index > n)
                begin
                    ans.index_error = 1'b1;
                end
                else
                begin
                    ans.point_value = VAL_W'(clamp_value(solution_copy[op.index]));
                end
            end
            default:
            begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void add_request(cmd_t cmd, int unsigned index,
                                        logic [VAL_W-1:0] u, logic [VAL_W-1:0] rhs);
        grid_op_t op;
        op.kind      = OP_REQUEST;
        op.cmd       = cmd;
        op.index     = IDX_W'(index);
        op.u_value   = u;
        op.rhs_value = rhs;
        op.reg_sel   = REG_INTERVAL_COUNT;
        op.reg_data  = '0;
        op_queue.push_back(op);
    endfunction

    function automatic void add_reg_write(cfg_reg_t sel, logic [VAL_W-1:0] data);
        grid_op_t op;
        op.kind      = OP_REG_WRITE;
        op.cmd       = CMD_NOP;
        op.index     = '0;
        op.u_value   = '0;
        op.rhs_value = '0;
        op.reg_sel   = sel;
        op.reg_data  = data;
        op_queue.push_back(op);
    endfunction

    function automatic void add_wait_idle();
        grid_op_t op;
        op.kind      = OP_WAIT_IDLE;
        op.cmd       = CMD_NOP;
        op.index     = '0;
        op.u_value   = '0;
        op.rhs_value = '0;
        op.reg_sel   = REG_INTERVAL_COUNT;
        op.reg_data  = '0;
        op_queue.push_back(op);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3, 4, 5: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            default: return $urandom();
        endcase
    endfunction

    // Writes all registers, loads every point up to n not yet written, then mixes random requests.
    function automatic void plan_phase(int unsigned n_reg, int unsigned steps,
                                       logic [VAL_W-1:0] h2, int unsigned items,
                                       int unsigned max_runs);
        int unsigned n;
        int unsigned runs;
        int unsigned idx;
        int unsigned pick;
        add_reg_write(REG_INTERVAL_COUNT, n_reg);
        add_reg_write(REG_SWEEP_STEPS, steps);
        add_reg_write(REG_STEP_SQUARED, h2);
        n = (n_reg > GRID_LAST) ? GRID_LAST : n_reg;
        for (int unsigned i = 0; i <= n; i++)
        begin
            if (!point_loaded[i])
            begin
                add_request(CMD_LOAD, i, pick_value(), pick_value());
                point_loaded[i] = 1'b1;
            end
        end
        runs = 0;
        for (int unsigned k = 0; k < items; k++)
        begin
            idx  = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, n);
            pick = $urandom_range(0, 99);
            if (pick < 2)
            begin
                add_wait_idle();
            end
            if (pick < 42)
            begin
                add_request(CMD_LOAD, idx, pick_value(), pick_value());
            end
            else if (pick < 57 && runs < max_runs)
            begin
                add_request(CMD_RUN, idx, $urandom(), $urandom());
                runs++;
            end
            else if (pick < 95)
            begin
                add_request(CMD_READ, idx, $urandom(), $urandom());
            end
            else
            begin
                add_request(CMD_NOP, idx, $urandom(), $urandom());
            end
            if (pick < 95)
            begin
                random_items++;
            end
        end
    endfunction

    task automatic report_mismatch(string field, longint want, longint got);
        if (mismatch_count < REPORT_CAP)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
        mismatch_count++;
    endtask

    // Driver: predicts each accepted request and paces the pending queue in bursts.
    always @(posedge clk or negedge rst_n)
    begin : driver
        grid_op_t head;
        answer_t  ans;
        bit       drive_req;
        bit       drive_cfg;
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.cmd       <= CMD_NOP;
            req_ch.index     <= '0;
            req_ch.u_value   <= '0;
            req_ch.rhs_value <= '0;
            cfg_ch.valid     <= 1'b0;
            cfg_ch.addr      <= REG_INTERVAL_COUNT;
            cfg_ch.data      <= '0;
            answers_due      <= 0;
            intervals_reg = INTERVAL_COUNT_RST;
            sweeps_reg    = SWEEP_STEPS_RST;
            h2_reg        = STEP_SQUARED_RST;
            burst_left    = 1;
            gap_left      = 0;
            quiet_cycles  = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (jacobi_answer(in_flight, ans))
                begin
                    expected_answers.push_back(ans);
                    answers_due <= answers_due + 1;
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_reg_t'(cfg_ch.addr))
                    REG_INTERVAL_COUNT: intervals_reg = cfg_ch.data[IDX_W-1:0];
                    REG_SWEEP_STEPS:    sweeps_reg    = cfg_ch.data[STEPS_W-1:0];
                    REG_STEP_SQUARED:   h2_reg        = cfg_ch.data;
                    default:            ;
                endcase
            end
            // The block counts as idle once no request is out and every answer has come.
            if (!req_ch.valid && answers_due == answers_seen)
            begin
                quiet_cycles++;
            end
            else
            begin
                quiet_cycles = 0;
            end
            if (!((req_ch.valid && !req_ch.ready) || (cfg_ch.valid && !cfg_ch.ready)))
            begin
                drive_req = 1'b0;
                drive_cfg = 1'b0;
                if (op_queue.size() != 0)
                begin
                    head = op_queue[0];
                    case (head.kind)
                        OP_REQUEST:
                        begin
                            if (gap_left != 0)
                            begin
                                gap_left--;
                            end
                            else
                            begin
                                in_flight = head;
                                drive_req = 1'b1;
                                void'(op_queue.pop_front());
                                burst_left--;
                                if (burst_left == 0)
                                begin
                                    if ($urandom_range(0, 9) == 0)
                                    begin
                                        burst_left = 64;
                                        gap_left   = 0;
                                    end
                                    else
                                    begin
                                        burst_left = $urandom_range(1, 24);
                                        gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                     : $urandom_range(1, 8);
                                    end
                                end
                            end
                        end
                        OP_REG_WRITE:
                        begin
                            if (quiet_cycles >= SETTLE_CYCLES)
                            begin
                                drive_cfg = 1'b1;
                                void'(op_queue.pop_front());
                            end
                        end
                        default:
                        begin
                            if (quiet_cycles >= SETTLE_CYCLES)
                            begin
                                void'(op_queue.pop_front());
                            end
                        end
                    endcase
                end
                req_ch.valid <= drive_req;
                if (drive_req)
                begin
                    req_ch.cmd       <= head.cmd;
                    req_ch.index     <= head.index;
                    req_ch.u_value   <= head.u_value;
                    req_ch.rhs_value <= head.rhs_value;
                end
                cfg_ch.valid <= drive_cfg;
                if (drive_cfg)
                begin
                    cfg_ch.addr <= head.reg_sel;
                    cfg_ch.data <= head.reg_data;
                end
            end
        end
    end

    // Monitor: checks each accepted answer and stalls the response channel.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        answer_t got;
        answer_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            answers_seen <= 0;
            stall_mode  = 0;
            mode_left   = 64;
            stall_phase = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.point_value = rsp_ch.point_value;
                got.run_done    = rsp_ch.run_done;
                got.index_error = rsp_ch.index_error;
                answers_seen <= answers_seen + 1;
                if (expected_answers.size() == 0)
                begin
                    if (mismatch_count < REPORT_CAP)
                    begin
                        $display("%0t: answer with no request outstanding: point_value %0d",
                                 $time, $signed(got.point_value));
                    end
                    mismatch_count++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (got.point_value !== want.point_value)
                    begin
                        report_mismatch("point_value", longint'($signed(want.point_value)),
                                        longint'($signed(got.point_value)));
                    end
                    if (got.run_done !== want.run_done)
                    begin
                        report_mismatch("run_done", want.run_done, got.run_done);
                    end
                    if (got.index_error !== want.index_error)
                    begin
                        report_mismatch("index_error", want.index_error, got.index_error);
                    end
                end
            end
            mode_left--;
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            stall_phase++;
            case (stall_mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= $urandom_range(0, 1);
                2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= ((stall_phase % 8) < 5);
            endcase
        end
    end

    initial
    begin : stimulus
        int unsigned n_reg;
        int unsigned steps;
        logic [VAL_W-1:0] h2;
        rst_n            = 1'b0;
        random_items     = 0;

        // Directed: value extremes so that both saturation directions show up in a sweep.
        add_reg_write(REG_INTERVAL_COUNT, 4);
        add_reg_write(REG_SWEEP_STEPS, 1);
        add_reg_write(REG_STEP_SQUARED, 32'hFFFF_FFFF);
        add_request(CMD_LOAD, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        add_request(CMD_LOAD, 1, 32'h0000_0000, 32'h7FFF_FFFF);
        add_request(CMD_LOAD, 2, 32'h7FFF_FFFF, 32'h0000_0000);
        add_request(CMD_LOAD, 3, 32'h8000_0000, 32'h8000_0000);
        add_request(CMD_LOAD, 4, 32'h8000_0000, 32'h7FFF_FFFF);
        for (int i = 0; i <= 4; i++)
        begin
            point_loaded[i] = 1'b1;
        end
        // Out-of-range loads must leave the grid untouched.
        add_request(CMD_LOAD, 5, 32'h1234_5678, 32'h7FFF_FFFF);
        add_request(CMD_LOAD, 2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(CMD_READ, 2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(CMD_READ, 5, 32'h0, 32'h0);
        add_request(CMD_NOP, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(CMD_RUN, 0, 32'h0, 32'h0);
        add_wait_idle();
        for (int i = 0; i <= 4; i++)
        begin
            add_request(CMD_READ, i, 32'h0, 32'h0);
        end
        // A single interval has no interior point: a run only answers.
        add_reg_write(REG_INTERVAL_COUNT, 1);
        add_reg_write(REG_SWEEP_STEPS, 5);
        add_reg_write(REG_STEP_SQUARED, 32'h0);
        add_request(CMD_RUN, 0, 32'h0, 32'h0);
        add_request(CMD_READ, 0, 32'h0, 32'h0);
        add_request(CMD_READ, 1, 32'h0, 32'h0);
        add_request(CMD_READ, 2, 32'h0, 32'h0);
        // No sweeps requested.
        add_reg_write(REG_INTERVAL_COUNT, 4);
        add_reg_write(REG_SWEEP_STEPS, 0);
        add_request(CMD_RUN, 0, 32'h0, 32'h0);
        add_request(CMD_READ, 1, 32'h0, 32'h0);

        // An interval count above the grid acts as the full grid.
        add_reg_write(REG_INTERVAL_COUNT, 2047);
        add_request(CMD_LOAD, 1024, 32'h0001_0000, 32'h0002_0000);
        add_request(CMD_LOAD, 1025, 32'h1234_5678, 32'h0);
        add_request(CMD_READ, 1024, 32'h0, 32'h0);
        add_request(CMD_READ, 1025, 32'h0, 32'h0);
        add_request(CMD_READ, 2047, 32'h0, 32'h0);
        add_reg_write(REG_INTERVAL_COUNT, 1024);
        add_request(CMD_LOAD, 1024, 32'h8000_0000, 32'h0);
        add_request(CMD_READ, 1024, 32'h0, 32'h0);
        add_request(CMD_READ, 1025, 32'h0, 32'h0);

        plan_phase(2, 65535, $urandom(), 10, 1);
        plan_phase(0, 3, 32'hFFFF_FFFF, 15, 3);
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       n_reg = $urandom_range(0, 1);
                1:       n_reg = $urandom_range(13, 64);
                default: n_reg = $urandom_range(2, 12);
            endcase
            steps = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
            case ($urandom_range(0, 4))
                0:       h2 = 32'h0;
                1:       h2 = 32'hFFFF_FFFF;
                2:       h2 = (n_reg < 2) ? 32'hFFFF_FFFF : VAL_W'((64'd1 << 32) / (n_reg * n_reg));
                default: h2 = $urandom();
            endcase
            plan_phase(n_reg, steps, h2, $urandom_range(30, 60), 12);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        while (op_queue.size() != 0 || req_ch.valid || cfg_ch.valid
               || answers_due != answers_seen)
        begin
            @(posedge clk);
        end
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_answers.size() == 0)
        begin
            $display("PASS jacobi_poisson_1d_solver_top");
        end
        else
        begin
            $display("FAIL jacobi_poisson_1d_solver_top");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("FAIL jacobi_poisson_1d_solver_top");
        $finish;
    end

endmodule
